>>> rtl/bf2d_pkg.sv
// Shared types and constants for the 2D box filter.
// No dependencies.
`timescale 1ns / 1ps
package bf2d_pkg;
	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int MaxKernel = 7;
	localparam int NLines    = MaxKernel - 1;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int RowW      = $clog2(MaxHeight);
	localparam int LineDepth = NLines * MaxWidth;
	localparam int LineAw    = $clog2(LineDepth);
	localparam int SumW      = 14;

	localparam logic [1:0] RegWidth  = 2'd0;
	localparam logic [1:0] RegHeight = 2'd1;
	localparam logic [1:0] RegKernel = 2'd2;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0]      value;
		logic [ColW-1:0] out_col;
		logic [RowW-1:0] out_row;
		logic            is_filtered;
		logic            last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture input and position
		logic fetch;    // issue line reads, row index in rd_row
		logic [2:0] rd_row;
		logic shift;    // shift window, write line store
		logic calc;     // compute sum and mean
	} dp_cmd_t;

	// reciprocal of K*K, scaled by 2^21, rounded up; exact for every window sum
	function automatic logic [21:0] recip(input logic [2:0] k);
		case (k)
			3'd1:    recip = 22'd2097152;
			3'd3:    recip = 22'd233017;
			3'd5:    recip = 22'd83887;
			3'd7:    recip = 22'd42800;
			default: recip = 22'd2097152;
		endcase
	endfunction
endpackage

>>> rtl/bf2d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bf2d_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

>>> rtl/bf2d_datapath.sv
// Datapath: line store, window, position tracking, sum and mean.
// Depends on bf2d_pkg and bf2d_ram.
`timescale 1ns / 1ps
module bf2d_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bf2d_pkg::in_item_t      in_item,
	input  bf2d_pkg::dp_cmd_t       cmd,
	input  logic [10:0]             width_q,
	input  logic [10:0]             height_q,
	input  logic [2:0]              kernel_q,
	output logic                    res_int,
	output logic                    res_border,
	output bf2d_pkg::out_item_t     res_mean,
	output bf2d_pkg::out_item_t     res_copy
);
	import bf2d_pkg::*;

	logic [ColW-1:0] col_q, c_q;
	logic [RowW-1:0] row_q, r_q;
	logic [7:0]      pix_q;
	logic [7:0]      win_q [MaxKernel][MaxKernel];
	logic [7:0]      rd_data;
	logic [2:0]      rd_row_q;
	logic            rd_vld_q;
	logic [7:0]      col_new_q [MaxKernel-1];
	logic [SumW-1:0] sum;
	logic [SumW+21:0] prod;
	logic [11:0]     w_eff, h_eff;
	logic [11:0]     c_pos, r_pos;
	logic [2:0]      half;
	logic            odd;
	logic [LineAw-1:0] raddr, waddr;
	logic [2:0]      rsel, wsel;
	logic [ColW-1:0] c_in;
	logic [RowW-1:0] r_in;
	logic [11:0]     c_nx;

	assign w_eff = (width_q == 11'd0) ? 12'd1 :
		(width_q > 11'(MaxWidth)) ? 12'(MaxWidth) : {1'b0, width_q};
	assign h_eff = (height_q == 11'd0) ? 12'd1 :
		(height_q > 11'(MaxHeight)) ? 12'(MaxHeight) : {1'b0, height_q};
	assign half = {1'b0, kernel_q[2:1]};
	assign odd  = kernel_q[0];

	// wrap the stored position before use
	always_comb begin
		c_in = in_item.frame_start ? '0 : col_q;
		r_in = in_item.frame_start ? '0 : row_q;
		if ({2'b0, c_in} >= w_eff) begin
			c_in = '0;
			r_in = r_in + 1'b1;
		end
		if ({2'b0, r_in} >= h_eff) r_in = '0;
	end

	// line slot select: (r + i) mod 6, with r mod 6 from a small reduction
	function automatic logic [2:0] mod6(input logic [RowW-1:0] v, input logic [2:0] add);
		logic [RowW+2:0] t;
		logic [RowW+2:0] qq;
		t  = {3'b0, v} + {{RowW{1'b0}}, add};
		qq = 13'((32'(t) * 32'd5462) >> 15);
		mod6 = 3'(t - 13'(qq * 6));
	endfunction

	assign rsel  = mod6(r_q, cmd.rd_row);
	assign wsel  = mod6(r_q, 3'd0);
	assign raddr = LineAw'(rsel) * LineAw'(MaxWidth) + LineAw'(c_q);
	assign waddr = LineAw'(wsel) * LineAw'(MaxWidth) + LineAw'(c_q);

	bf2d_ram #(.Width(8), .Depth(LineDepth)) u_line (
		.clk(clk), .we(cmd.shift), .waddr(waddr), .wdata(pix_q),
		.re(cmd.fetch), .raddr(raddr), .rdata(rd_data));

	// capture input, advance position
	assign c_nx = {2'b0, c_in} + 12'd1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= cmd.fetch;
			if (cmd.load) begin
				if (c_nx >= w_eff) begin
					col_q <= '0;
					row_q <= ({2'b0, r_in} + 12'd1 >= h_eff) ? '0 : r_in + 1'b1;
				end else begin
					col_q <= c_nx[ColW-1:0];
					row_q <= r_in;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= in_item.pixel;
			c_q   <= c_in;
			r_q   <= r_in;
		end
		if (cmd.fetch) rd_row_q <= cmd.rd_row;
		if (rd_vld_q) col_new_q[rd_row_q] <= rd_data;
	end

	// shift window left, insert the new column
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int i = 0; i < MaxKernel; i++) begin
				for (int j = 0; j < MaxKernel - 1; j++) win_q[i][j] <= win_q[i][j+1];
				win_q[i][MaxKernel-1] <= (i == MaxKernel - 1) ? pix_q : col_new_q[i];
			end
		end
	end

	// sum of the active KxK corner
	always_comb begin
		sum = '0;
		for (int i = 0; i < MaxKernel; i++)
			for (int j = 0; j < MaxKernel; j++)
				if (i >= MaxKernel - int'(kernel_q) && j >= MaxKernel - int'(kernel_q))
					sum = sum + SumW'(win_q[i][j]);
	end

	logic [SumW-1:0] sum_s1;
	always_ff @(posedge clk) if (cmd.calc) sum_s1 <= sum;
	assign prod = sum_s1 * recip(kernel_q);

	assign c_pos = {2'b0, c_q};
	assign r_pos = {2'b0, r_q};
	assign res_int = odd && c_pos >= 12'(2 * half) && r_pos >= 12'(2 * half);
	assign res_border = !odd || c_pos < 12'(half) || r_pos < 12'(half)
		|| c_pos + 12'(half) >= w_eff || r_pos + 12'(half) >= h_eff;

	assign res_mean.value       = prod[28:21];
	assign res_mean.out_col     = c_q - ColW'(half);
	assign res_mean.out_row     = r_q - RowW'(half);
	assign res_mean.is_filtered = 1'b1;
	assign res_mean.last        = !res_border;
	assign res_copy.value       = pix_q;
	assign res_copy.out_col     = c_q;
	assign res_copy.out_row     = r_q;
	assign res_copy.is_filtered = 1'b0;
	assign res_copy.last        = 1'b1;
	logic unused;
	assign unused = ^{prod[SumW+21:29], prod[20:0]};
endmodule

>>> rtl/bf2d_ctrl.sv
// Controller: sequences line reads, window shift, mean and output.
// Depends on bf2d_pkg.
`timescale 1ns / 1ps
module bf2d_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_sel,  // 0 mean, 1 copy
	input  logic                res_int,
	input  logic                res_border,
	output bf2d_pkg::dp_cmd_t   cmd
);
	import bf2d_pkg::*;

	typedef enum logic [2:0] {
		IDLE, FETCH, DRAIN, SHIFT, CALC, EMIT_MEAN, EMIT_COPY
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = (state_q == EMIT_MEAN) || (state_q == EMIT_COPY);
	assign out_sel   = (state_q == EMIT_COPY);

	always_comb begin
		cmd = '0;
		cmd.load   = in_valid && in_ready;
		cmd.fetch  = (state_q == FETCH);
		cmd.rd_row = cnt_q;
		cmd.shift  = (state_q == SHIFT);
		cmd.calc   = (state_q == CALC);
	end

	// step through one item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				IDLE: if (in_valid) begin
					state_q <= FETCH;
					cnt_q   <= '0;
				end
				FETCH: begin
					if (cnt_q == 3'(NLines - 1)) state_q <= DRAIN;
					else cnt_q <= cnt_q + 1'b1;
				end
				DRAIN: state_q <= SHIFT;
				SHIFT: state_q <= CALC;
				// a pixel that closes no window and is not a border pixel has no result
				CALC: state_q <= res_int ? EMIT_MEAN : (res_border ? EMIT_COPY : IDLE);
				EMIT_MEAN: if (out_ready) state_q <= res_border ? EMIT_COPY : IDLE;
				EMIT_COPY: if (out_ready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

>>> rtl/box_filter_2d_no_border.sv
// Top level of the 2D box filter: config registers, controller, datapath.
// Depends on bf2d_pkg, bf2d_ctrl, bf2d_datapath.
//
// channel  | signals                     | moves
// in       | in_valid/in_ready/in_item   | one pixel request
// out      | out_valid/out_ready/out_item| one result
// cfg      | cfg_valid/cfg_ready/idx/data| one register write
//
// An item has one emit state per result (zero, one or two) and is paced by the
// six serial line-store reads through the single read port. No clearing pass
// after reset. A stalled output holds the controller; config is always accepted.
`timescale 1ns / 1ps
module box_filter_2d_no_border (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bf2d_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bf2d_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [10:0]          cfg_data
);
	import bf2d_pkg::*;

	logic [10:0] width_q, height_q;
	logic [2:0]  kernel_q;
	dp_cmd_t     cmd;
	logic        res_int, res_border, out_sel;
	out_item_t   res_mean, res_copy;

	assign cfg_ready = 1'b1;

	// hold config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 11'd480;
			kernel_q <= 3'd7;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegWidth:  width_q  <= cfg_data;
				RegHeight: height_q <= cfg_data;
				RegKernel: kernel_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	bf2d_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .out_sel(out_sel),
		.res_int(res_int), .res_border(res_border), .cmd(cmd));

	bf2d_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd),
		.width_q(width_q), .height_q(height_q), .kernel_q(kernel_q),
		.res_int(res_int), .res_border(res_border),
		.res_mean(res_mean), .res_copy(res_copy));

	assign out_item = out_sel ? res_copy : res_mean;
endmodule

>>> rtl/bf2d_checker.sv
// Port-level checker for the box filter, bound to the top level.
// Depends on bf2d_pkg.
`timescale 1ns / 1ps
module bf2d_props (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input bf2d_pkg::out_item_t out_item
);
	// no new request while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("in_ready with out_valid");
	// a mean result that is not last is followed by the copy
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.last |=> out_valid && !out_item.is_filtered)
		else $error("missing copy after mean");
	// a copy result always closes the item
	a_copy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.is_filtered |-> out_item.last)
		else $error("copy not last");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result dropped");
endmodule

bind box_filter_2d_no_border bf2d_props u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item));
